FILE: rtl/core/mcinv_pkg.sv
// mcinv_pkg: widths, word types and minor tables for the 3x3 inverse/cofactor block
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps

package mcinv_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NL         = 9;

  // product, cofactor, determinant, divisor and remainder widths
  localparam int PW = 2 * ELEM_WIDTH + 1;
  localparam int CW = 2 * ELEM_WIDTH + 1;
  localparam int DW = 3 * ELEM_WIDTH + 2;
  localparam int YW = DW + 1;
  localparam int RW = DW + ELEM_WIDTH + 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTRW  = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVW   = $clog2(FIFO_DEPTH + 1);

  typedef logic [ELEM_WIDTH-1:0] elem_t;
  typedef logic [CW-1:0]         cof_t;
  typedef logic [DW-1:0]         det_t;
  typedef logic [YW-1:0]         divisor_t;
  typedef logic [RW-1:0]         rem_t;

  typedef struct packed {
    logic  func;
    elem_t a00;
    elem_t a01;
    elem_t a02;
    elem_t a10;
    elem_t a11;
    elem_t a12;
    elem_t a20;
    elem_t a21;
    elem_t a22;
  } req_word_t;

  typedef struct packed {
    elem_t out_00;
    elem_t out_01;
    elem_t out_02;
    elem_t out_10;
    elem_t out_11;
    elem_t out_12;
    elem_t out_20;
    elem_t out_21;
    elem_t out_22;
    elem_t determinant;
    logic  singular;
  } rsp_word_t;

  typedef struct packed {
    logic               func;
    elem_t [2:0]        row0;
    cof_t  [NL-1:0]     cof;
  } cof_word_t;

  // cofactor k = a[MP]*a[MQ] - a[MR]*a[MS], row-major element indexes
  localparam int MP [NL] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
  localparam int MQ [NL] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
  localparam int MR [NL] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
  localparam int MS [NL] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

endpackage

FILE: rtl/core/mcinv_if.sv
// mcinv channel interfaces: request, response and internal cofactor words
// depends on mcinv_pkg for the payload types
`timescale 1ns / 1ps

interface mcinv_req_if;
  logic                  valid;
  logic                  ready;
  mcinv_pkg::req_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mcinv_rsp_if;
  logic                  valid;
  logic                  ready;
  mcinv_pkg::rsp_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mcinv_cof_if;
  logic                  valid;
  logic                  ready;
  mcinv_pkg::cof_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/mcinv_front.sv
// mcinv_front: accepts matrices, forms the 18 products and the nine exact cofactors
// depends on mcinv_pkg and mcinv_if
`timescale 1ns / 1ps

module mcinv_front (
  input  logic              clk,
  input  logic              rst,
  mcinv_req_if.sink         req,
  mcinv_cof_if.source       cof
);

  localparam int W  = mcinv_pkg::ELEM_WIDTH;
  localparam int NL = mcinv_pkg::NL;

  mcinv_pkg::elem_t a [NL];

  logic                         v1, v2, en;
  logic                         func1;
  mcinv_pkg::elem_t [2:0]       row1;
  logic signed [2*W-1:0]        pa [NL];
  logic signed [2*W-1:0]        pb [NL];
  mcinv_pkg::cof_word_t         word2;

  assign a[0] = req.data.a00;
  assign a[1] = req.data.a01;
  assign a[2] = req.data.a02;
  assign a[3] = req.data.a10;
  assign a[4] = req.data.a11;
  assign a[5] = req.data.a12;
  assign a[6] = req.data.a20;
  assign a[7] = req.data.a21;
  assign a[8] = req.data.a22;

  assign en        = !v2 || cof.ready;
  assign req.ready = en;
  assign cof.valid = v2;
  assign cof.data  = word2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func1 <= req.data.func;
      row1  <= {a[2], a[1], a[0]};
      for (int k = 0; k < NL; k++) begin
        pa[k] <= $signed(a[mcinv_pkg::MP[k]]) * $signed(a[mcinv_pkg::MQ[k]]);
        pb[k] <= $signed(a[mcinv_pkg::MR[k]]) * $signed(a[mcinv_pkg::MS[k]]);
      end
      word2.func <= func1;
      word2.row0 <= row1;
      for (int k = 0; k < NL; k++) begin
        word2.cof[k] <= {pa[k][2*W-1], pa[k]} - {pb[k][2*W-1], pb[k]};
      end
    end
  end

endmodule

FILE: rtl/core/mcinv_fifo.sv
// mcinv_fifo: short queue of cofactor words between the front and back parts
// depends on mcinv_pkg and mcinv_if
`timescale 1ns / 1ps

module mcinv_fifo (
  input  logic                                clk,
  input  logic                                rst,
  mcinv_cof_if.sink                           push,
  mcinv_cof_if.source                         pop,
  output logic [mcinv_pkg::FIFO_LVW-1:0]      level
);

  localparam int DEPTH = mcinv_pkg::FIFO_DEPTH;
  localparam int PTRW  = mcinv_pkg::FIFO_PTRW;
  localparam int LVW   = mcinv_pkg::FIFO_LVW;

  mcinv_pkg::cof_word_t  mem [DEPTH];
  logic [PTRW-1:0]       wr_ptr, rd_ptr;
  logic                  do_push, do_pop;

  assign push.ready = (level != LVW'(DEPTH));
  assign pop.valid  = (level != '0);
  assign pop.data   = mem[rd_ptr];
  assign do_push    = push.valid && push.ready;
  assign do_pop     = pop.valid && pop.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTRW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTRW'(1);
      if (do_push && !do_pop)      level <= level + LVW'(1);
      else if (do_pop && !do_push) level <= level - LVW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push.data;
  end

endmodule

FILE: rtl/core/mcinv_div.sv
// mcinv_div: nine-lane restoring divider, one quotient bit per pipeline stage
// depends on mcinv_pkg; stalls as a whole on en
`timescale 1ns / 1ps

module mcinv_div (
  input  logic                                         clk,
  input  logic                                         en,
  input  mcinv_pkg::rem_t [mcinv_pkg::NL-1:0]          x,
  input  mcinv_pkg::divisor_t                          y,
  output logic [mcinv_pkg::NL-1:0][mcinv_pkg::ELEM_WIDTH-1:0] q,
  output logic [mcinv_pkg::NL-1:0]                     over
);

  localparam int W  = mcinv_pkg::ELEM_WIDTH;
  localparam int NL = mcinv_pkg::NL;

  mcinv_pkg::rem_t [NL-1:0]     r  [W-1];
  mcinv_pkg::divisor_t          ys [W-1];
  logic [NL-1:0][W-1:0]         qs [W];
  logic [NL-1:0]                ov [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int K = W - 1 - s;

    mcinv_pkg::rem_t [NL-1:0]   r_in;
    logic [NL-1:0][W-1:0]       q_in;
    logic [NL-1:0]              ov_in;
    mcinv_pkg::divisor_t        y_in;
    mcinv_pkg::rem_t            ysh;
    logic [NL-1:0]              ge;

    if (s == 0) begin : g_first
      // quotient beyond the top bit only matters as a saturation flag
      always_comb begin
        r_in = x;
        q_in = '0;
        y_in = y;
        for (int l = 0; l < NL; l++) begin
          ov_in[l] = (x[l] >= (mcinv_pkg::rem_t'(y) << W));
        end
      end
    end else begin : g_next
      always_comb begin
        r_in  = r[s-1];
        q_in  = qs[s-1];
        y_in  = ys[s-1];
        ov_in = ov[s-1];
      end
    end

    always_comb begin
      ysh = mcinv_pkg::rem_t'(y_in) << K;
      for (int l = 0; l < NL; l++) ge[l] = (r_in[l] >= ysh);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ov[s] <= ov_in;
        for (int l = 0; l < NL; l++) begin
          qs[s][l] <= q_in[l] | (ge[l] ? (W'(1) << K) : W'(0));
        end
      end
    end

    if (s < W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          ys[s] <= y_in;
          for (int l = 0; l < NL; l++) begin
            r[s][l] <= ge[l] ? (r_in[l] - ysh) : r_in[l];
          end
        end
      end
    end
  end

  assign q    = qs[W-1];
  assign over = ov[W-1];

endmodule

FILE: rtl/core/mcinv_back.sv
// mcinv_back: determinant, rounding, division and saturation, output register
// depends on mcinv_pkg, mcinv_if and mcinv_div
`timescale 1ns / 1ps

module mcinv_back (
  input  logic              clk,
  input  logic              rst,
  mcinv_cof_if.sink         cof,
  mcinv_rsp_if.source       rsp
);

  localparam int W  = mcinv_pkg::ELEM_WIDTH;
  localparam int F  = mcinv_pkg::FRAC_BITS;
  localparam int NL = mcinv_pkg::NL;
  localparam int PW = mcinv_pkg::PW;
  localparam int CW = mcinv_pkg::CW;
  localparam int DW = mcinv_pkg::DW;
  localparam int RW = mcinv_pkg::RW;

  typedef struct packed {
    logic                              func;
    logic                              sing;
    mcinv_pkg::elem_t                  det;
    logic [NL-1:0]                     neg;
    mcinv_pkg::elem_t [NL-1:0]         alt;
  } side_t;

  function automatic mcinv_pkg::elem_t sat_mag(input logic neg, input mcinv_pkg::rem_t mag);
    mcinv_pkg::rem_t lim;
    mcinv_pkg::rem_t m;
    lim = (RW'(1) << (W - 1)) - (neg ? RW'(0) : RW'(1));
    m   = (mag > lim) ? lim : mag;
    m   = neg ? (RW'(0) - m) : m;
    return m[W-1:0];
  endfunction

  logic en;
  logic v1, v2, v3, v4, vout;
  logic [W-1:0] vd;

  // stage 1: split products row0 x cofactor
  logic                                func1, func2, func3;
  mcinv_pkg::cof_t [NL-1:0]            cof1, cof2, cof3;
  logic signed [PW-1:0]                ph [3];
  logic signed [PW-1:0]                pl [3];
  mcinv_pkg::det_t                     t2 [3];
  mcinv_pkg::det_t                     d3;

  // stage 4: divider operands and rounded side results
  mcinv_pkg::det_t                     dmag;
  logic                                dsign;
  mcinv_pkg::rem_t [NL-1:0]            x_n, x4;
  logic [NL-1:0]                       neg_n;
  mcinv_pkg::elem_t [NL-1:0]           alt_n;
  mcinv_pkg::divisor_t                 y4;
  side_t                               side4;
  side_t                               sd [W];

  logic [NL-1:0][W-1:0]                q;
  logic [NL-1:0]                       over;
  mcinv_pkg::elem_t [NL-1:0]           res;
  mcinv_pkg::rsp_word_t                dout;

  assign en        = !vout || rsp.ready;
  assign cof.ready = en;
  assign rsp.valid = vout;
  assign rsp.data  = dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      vd   <= '0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= cof.valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      vd   <= {vd[W-2:0], v4};
      vout <= vd[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func1 <= cof.data.func;
      cof1  <= cof.data.cof;
      for (int k = 0; k < 3; k++) begin
        ph[k] <= $signed(cof.data.row0[k]) * $signed(cof.data.cof[k][CW-1:W]);
        pl[k] <= $signed(cof.data.row0[k]) * $signed({1'b0, cof.data.cof[k][W-1:0]});
      end
      func2 <= func1;
      cof2  <= cof1;
      for (int k = 0; k < 3; k++) begin
        t2[k] <= ({{(DW-PW){ph[k][PW-1]}}, ph[k]} << W) + {{(DW-PW){pl[k][PW-1]}}, pl[k]};
      end
      func3 <= func2;
      cof3  <= cof2;
      d3    <= t2[0] + t2[1] + t2[2];
    end
  end

  assign dsign = d3[DW-1];
  assign dmag  = dsign ? (DW'(0) - d3) : d3;

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int L = 3 * i + j;
      localparam int T = 3 * j + i;
      logic            cs, as;
      mcinv_pkg::cof_t cm, am;
      always_comb begin
        // inverse element (i,j) divides the transposed cofactor
        cs       = cof3[T][CW-1];
        cm       = cs ? (CW'(0) - cof3[T]) : cof3[T];
        x_n[L]   = (RW'(cm) << (2 * F + 1)) + RW'(dmag);
        neg_n[L] = cs ^ dsign;
        as       = cof3[L][CW-1];
        am       = as ? (CW'(0) - cof3[L]) : cof3[L];
        alt_n[L] = sat_mag(as, (RW'(am) + (RW'(1) << (F - 1))) >> F);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x4         <= x_n;
      y4         <= {dmag, 1'b0};
      side4.func <= func3;
      side4.sing <= (d3 == '0);
      side4.det  <= sat_mag(dsign, (RW'(dmag) + (RW'(1) << (2 * F - 1))) >> (2 * F));
      side4.neg  <= neg_n;
      side4.alt  <= alt_n;
      sd[0]      <= side4;
      for (int s = 1; s < W; s++) sd[s] <= sd[s-1];
    end
  end

  mcinv_div u_div (
    .clk  (clk),
    .en   (en),
    .x    (x4),
    .y    (y4),
    .q    (q),
    .over (over)
  );

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (sd[W-1].func) res[l] = sd[W-1].alt[l];
      else if (sd[W-1].sing) res[l] = '0;
      else res[l] = sat_mag(sd[W-1].neg[l], RW'({over[l], q[l]}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.out_00      <= res[0];
      dout.out_01      <= res[1];
      dout.out_02      <= res[2];
      dout.out_10      <= res[3];
      dout.out_11      <= res[4];
      dout.out_12      <= res[5];
      dout.out_20      <= res[6];
      dout.out_21      <= res[7];
      dout.out_22      <= res[8];
      dout.determinant <= sd[W-1].det;
      dout.singular    <= sd[W-1].sing;
    end
  end

endmodule

FILE: rtl/core/matrix3x3_inverse_cofactor_top.sv
// matrix3x3_inverse_cofactor_top: 3x3 inverse / cofactor matrix of Q16.16 elements
// depends on mcinv_pkg, mcinv_if, mcinv_front, mcinv_fifo, mcinv_back
//
// req carries func and a row-major matrix a00..a22; rsp returns out_00..out_22,
// the determinant and the singular flag, one result word per request word.
// func 0 gives the inverse (adjugate over determinant, rounded, saturated,
// all zero when singular); func 1 gives the rounded cofactor matrix.
// both channels move a word when valid and ready are high at a clock edge.
// throughput: one word per cycle while the receiver keeps rsp.ready high, fully pipelined.
// from acceptance to rsp.valid a word passes the product/cofactor front, the queue,
// determinant and operand prep, the divider (one quotient bit per stage) and the
// output register.
// a stalled receiver freezes the back pipeline; the 4-word queue keeps the
// front accepting until it fills, after which req.ready drops.
// synchronous reset on rst clears every valid and the queue; no word is
// delivered the cycle after reset.
`timescale 1ns / 1ps

module matrix3x3_inverse_cofactor_top (
  input  logic          clk,
  input  logic          rst,
  mcinv_req_if.sink     req,
  mcinv_rsp_if.source   rsp
);

  mcinv_cof_if f2q ();
  mcinv_cof_if q2b ();

  logic [mcinv_pkg::FIFO_LVW-1:0] q_level;

  mcinv_front u_front (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cof (f2q)
  );

  mcinv_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (f2q),
    .pop   (q2b),
    .level (q_level)
  );

  mcinv_back u_back (
    .clk (clk),
    .rst (rst),
    .cof (q2b),
    .rsp (rsp)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("rsp valid after reset");

  a_singular_det: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.singular |-> rsp.data.determinant == '0)
    else $error("singular word with nonzero determinant");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= mcinv_pkg::FIFO_LVW'(mcinv_pkg::FIFO_DEPTH))
    else $error("queue level beyond depth");

endmodule
